### hw/rtl/mdee_pkg.sv
// ----------------------------------------------------------------------------
// mdee_pkg
// Shared types and constants of the extended-Euclid modular divider.
// ----------------------------------------------------------------------------
package mdee_pkg;

  localparam int DIVIDEND_W = 63;
  localparam int DIVISOR_W  = 32;
  localparam int QUOT_W     = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CNT_W      = $clog2(DIVIDEND_W + 1);

  localparam logic [CFG_DATA_W-1:0] MOD_RESET = 32'd1000000007;

  // register index, taken from the word address bit
  localparam logic CFG_IDX_MODULUS = 1'b0;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_UPDATE,
    ST_FINAL,
    ST_DBL,
    ST_DBL_RED,
    ST_ADD,
    ST_ADD_RED,
    ST_PUT
  } state_t;

endpackage

### hw/rtl/mdee_alu.sv
// ----------------------------------------------------------------------------
// mdee_alu
// Shared adder/subtractor used by every step of the divider.
// ----------------------------------------------------------------------------
module mdee_alu
  import mdee_pkg::*;
#(
  parameter int AW = 34
) (
  input  alu_op_t       op,
  input  logic [AW-1:0] x,
  input  logic [AW-1:0] y,
  output logic [AW-1:0] sum,
  output logic          neg
);

  always_comb begin
    unique case (op)
      ALU_ADD: sum = x + y;
      ALU_SUB: sum = x - y;
      default: sum = x + y;
    endcase
  end

  assign neg = sum[AW-1];

endmodule

### hw/rtl/mdee_seq.sv
// ----------------------------------------------------------------------------
// mdee_seq
// Sequencer and datapath registers: reductions, Euclid steps, final product.
// ----------------------------------------------------------------------------
module mdee_seq
  import mdee_pkg::*;
#(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [W-1:0]          modulus,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [QUOT_W-1:0]     quotient,
  output logic                  no_inverse
);

  localparam int AW  = W + 2;
  localparam int SHW = DIVIDEND_W;

  state_t                state, state_next;
  logic [CNT_W-1:0]      cnt, cnt_next;
  logic [SHW-1:0]        shreg, shreg_next;
  logic [AW-1:0]         rem, rem_next;
  logic [AW-1:0]         acc, acc_next;
  logic [AW-1:0]         t0, t0_next;
  logic [AW-1:0]         t1, t1_next;
  logic [W-1:0]          r0, r0_next;
  logic [W-1:0]          r1, r1_next;
  logic [W-1:0]          ar, ar_next;
  logic [DIVISOR_W-1:0]  bval, bval_next;
  logic                  noinv, noinv_next;
  logic                  out_valid_next;
  logic [QUOT_W-1:0]     quotient_next;
  logic                  no_inverse_next;

  alu_op_t               alu_op;
  logic [AW-1:0]         alu_x, alu_y, alu_sum;
  logic                  alu_neg;
  logic [AW-1:0]         cand;
  logic [AW-1:0]         mod_ext;
  logic [AW-1:0]         inv;

  mdee_alu #(.AW(AW)) u_alu (
    .op (alu_op),
    .x  (alu_x),
    .y  (alu_y),
    .sum(alu_sum),
    .neg(alu_neg)
  );

  assign in_ready = (state == ST_IDLE);
  assign cand     = {rem[AW-2:0], shreg[SHW-1]};
  assign mod_ext  = AW'(modulus);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt        <= cnt_next;
    shreg      <= shreg_next;
    rem        <= rem_next;
    acc        <= acc_next;
    t0         <= t0_next;
    t1         <= t1_next;
    r0         <= r0_next;
    r1         <= r1_next;
    ar         <= ar_next;
    bval       <= bval_next;
    noinv      <= noinv_next;
    quotient   <= quotient_next;
    no_inverse <= no_inverse_next;
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    shreg_next      = shreg;
    rem_next        = rem;
    acc_next        = acc;
    t0_next         = t0;
    t1_next         = t1;
    r0_next         = r0;
    r1_next         = r1;
    ar_next         = ar;
    bval_next       = bval;
    noinv_next      = noinv;
    quotient_next   = quotient;
    no_inverse_next = no_inverse;
    out_valid_next  = out_valid && !out_ready;
    alu_op          = ALU_ADD;
    alu_x           = acc;
    alu_y           = acc;
    inv             = t0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          shreg_next = dividend;
          bval_next  = divisor;
          rem_next   = '0;
          cnt_next   = CNT_W'(DIVIDEND_W - 1);
          if (modulus == '0) begin
            noinv_next = 1'b1;
            state_next = ST_PUT;
          end else begin
            noinv_next = 1'b0;
            state_next = ST_RED_A;
          end
        end
      end

      ST_RED_A, ST_RED_B, ST_DIV: begin
        alu_op     = ALU_SUB;
        alu_x      = cand;
        alu_y      = (state == ST_DIV) ? AW'(r1) : mod_ext;
        rem_next   = alu_neg ? cand : alu_sum;
        shreg_next = {shreg[SHW-2:0], !alu_neg};
        cnt_next   = cnt - 1'b1;
        if (cnt == '0) begin
          unique case (state)
            ST_RED_A: begin
              ar_next    = rem_next[W-1:0];
              rem_next   = '0;
              shreg_next = SHW'(bval) << (SHW - DIVISOR_W);
              cnt_next   = CNT_W'(DIVISOR_W - 1);
              state_next = ST_RED_B;
            end
            ST_RED_B: begin
              r1_next    = rem_next[W-1:0];
              r0_next    = modulus;
              t0_next    = '0;
              t1_next    = AW'(1);
              state_next = ST_CHECK;
            end
            default: begin
              acc_next   = '0;
              cnt_next   = CNT_W'(W - 1);
              state_next = ST_MUL;
            end
          endcase
        end
      end

      ST_CHECK: begin
        if (r1 == '0) begin
          state_next = ST_FINAL;
        end else begin
          rem_next   = '0;
          shreg_next = SHW'(r0) << (SHW - W);
          cnt_next   = CNT_W'(W - 1);
          state_next = ST_DIV;
        end
      end

      ST_MUL: begin
        alu_op     = ALU_SUB;
        alu_x      = {acc[AW-2:0], 1'b0};
        alu_y      = shreg[W-1] ? t1 : '0;
        acc_next   = alu_sum;
        shreg_next = {shreg[SHW-2:0], 1'b0};
        cnt_next   = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        alu_op     = ALU_ADD;
        alu_x      = t0;
        alu_y      = acc;
        t0_next    = t1;
        t1_next    = alu_sum;
        r0_next    = r1;
        r1_next    = rem[W-1:0];
        state_next = ST_CHECK;
      end

      ST_FINAL: begin
        alu_op = ALU_ADD;
        alu_x  = t0;
        alu_y  = mod_ext;
        inv    = t0[AW-1] ? alu_sum : t0;
        if (r0 != W'(1)) begin
          noinv_next = 1'b1;
          state_next = ST_PUT;
        end else begin
          shreg_next = SHW'(inv[W-1:0]) << (SHW - W);
          acc_next   = '0;
          cnt_next   = CNT_W'(W - 1);
          state_next = ST_DBL;
        end
      end

      ST_DBL: begin
        alu_op     = ALU_ADD;
        alu_x      = acc;
        alu_y      = acc;
        acc_next   = alu_sum;
        state_next = ST_DBL_RED;
      end

      ST_ADD: begin
        alu_op     = ALU_ADD;
        alu_x      = acc;
        alu_y      = AW'(ar);
        acc_next   = alu_sum;
        state_next = ST_ADD_RED;
      end

      ST_DBL_RED, ST_ADD_RED: begin
        alu_op   = ALU_SUB;
        alu_x    = acc;
        alu_y    = mod_ext;
        acc_next = alu_neg ? acc : alu_sum;
        if (state == ST_DBL_RED && shreg[SHW-1]) begin
          state_next = ST_ADD;
        end else begin
          shreg_next = {shreg[SHW-2:0], 1'b0};
          cnt_next   = cnt - 1'b1;
          state_next = (cnt == '0) ? ST_PUT : ST_DBL;
        end
      end

      ST_PUT: begin
        if (!out_valid || out_ready) begin
          out_valid_next  = 1'b1;
          quotient_next   = noinv ? '0 : QUOT_W'(acc[W-1:0]);
          no_inverse_next = noinv;
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_noinv_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && no_inverse) |-> (quotient == '0))
    else $error("no-inverse result with nonzero quotient");

  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !no_inverse) |-> (modulus == '0 || 64'(quotient) < 64'(modulus)))
    else $error("quotient not reduced");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < AW'(r1)))
    else $error("partial remainder not below divisor");

  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DBL || state == ST_ADD) |-> (acc < mod_ext))
    else $error("product accumulator not reduced");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready held after accepting an item");

endmodule

### hw/rtl/modular_divide_ext_euclid_top.sv
// Throughput: one item at a time; s_tready is low from accept until the result
//   is placed in the output register. Every step goes through the one shared adder.
// A result may wait in the output register while the next item is taken.
// Reset (rst, synchronous): sequencer idle, output empty, modulus = 1000000007.
// ----------------------------------------------------------------------------
// modular_divide_ext_euclid_top
// Modular divider: dividend * divisor^-1 mod modulus by extended Euclid.
// ----------------------------------------------------------------------------
module modular_divide_ext_euclid_top
  import mdee_pkg::*;
#(
  parameter int MOD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [95:0]           s_tdata,  // dividend[62:0], divisor[94:63], zero[95]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [QUOT_W-1:0]     m_tdata,  // quotient[31:0]
  output logic                  m_tuser   // no_inverse[0]
);

  logic [MOD_WIDTH-1:0] modulus;
  logic                 reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_W-1] == CFG_IDX_MODULUS) && (paddr[1:0] == 2'b00)
                   || (paddr[CFG_ADDR_W-1] == CFG_IDX_MODULUS);
  assign prdata  = reg_sel ? CFG_DATA_W'(modulus) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_WIDTH'(MOD_RESET);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      modulus <= MOD_WIDTH'(pwdata);
    end
  end

  mdee_seq #(.W(MOD_WIDTH)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .modulus   (modulus),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .dividend  (s_tdata[DIVIDEND_W-1:0]),
    .divisor   (s_tdata[DIVIDEND_W+DIVISOR_W-1:DIVIDEND_W]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .quotient  (m_tdata),
    .no_inverse(m_tuser)
  );

endmodule

### dv/modular_divide_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_divide_checker
// Watches the register port and both item streams of the modular divider.
// Keeps its own copy of the modulus and predicts every quotient and
// no-inverse flag by extended Euclid. Results are compared in order.
// Register reads are checked as well.
// ----------------------------------------------------------------------------
module modular_divide_checker
  import mdee_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic [CFG_DATA_W-1:0] prdata,
  input  logic                  pready,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [95:0]           s_tdata,  // dividend[62:0], divisor[94:63], zero[95]
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [QUOT_W-1:0]     m_tdata,  // quotient[31:0]
  input  logic                  m_tuser,  // no_inverse[0]
  output int                    mismatches,
  output int                    pending
);

  typedef struct packed {
    logic [QUOT_W-1:0] quotient;
    logic              no_inverse;
  } quot_item_t;

  logic [CFG_DATA_W-1:0] modulus;
  quot_item_t            quot_queue[$];

  function automatic quot_item_t divide_mod(input logic [DIVIDEND_W-1:0] dividend,
                                            input logic [DIVISOR_W-1:0]  divisor,
                                            input logic [CFG_DATA_W-1:0] m);
    longint unsigned r_prev, r_cur, r_next, q, inv, num;
    longint          s_prev, s_cur, s_next, m_s;
    quot_item_t      res;
    res = '0;
    if (m == '0) begin
      res.no_inverse = 1'b1;
      return res;
    end
    m_s    = longint'(m);
    r_prev = 64'(m);
    r_cur  = 64'(divisor % m);
    s_prev = 0;
    s_cur  = 1;
    while (r_cur != 0) begin
      q      = r_prev / r_cur;
      r_next = r_prev - q * r_cur;
      s_next = s_prev - longint'(q) * s_cur;
      r_prev = r_cur;
      r_cur  = r_next;
      s_prev = s_cur;
      s_cur  = s_next;
    end
    if (r_prev != 1) begin
      res.no_inverse = 1'b1;
      return res;
    end
    s_prev = s_prev % m_s;
    if (s_prev < 0) s_prev = s_prev + m_s;
    inv = s_prev;
    num = {1'b0, dividend} % 64'(m);
    res.quotient = QUOT_W'((inv * num) % 64'(m));
    return res;
  endfunction

  always @(posedge clk) begin
    quot_item_t want;
    if (rst) begin
      modulus = MOD_RESET;
      quot_queue.delete();
      mismatches = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (quot_queue.size() == 0) begin
          $error("result with none pending: quotient %0d no_inverse %0d", m_tdata, m_tuser);
          mismatches++;
        end else begin
          want = quot_queue.pop_front();
          if (m_tdata !== want.quotient) begin
            $error("quotient: expected %0d, actual %0d", want.quotient, m_tdata);
            mismatches++;
          end
          if (m_tuser !== want.no_inverse) begin
            $error("no_inverse: expected %0d, actual %0d", want.no_inverse, m_tuser);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready)
        quot_queue = {quot_queue, divide_mod(s_tdata[DIVIDEND_W-1:0],
                                             s_tdata[DIVIDEND_W +: DIVISOR_W], modulus)};
      if (psel && penable && pready && paddr[2] == CFG_IDX_MODULUS) begin
        if (pwrite) begin
          modulus = pwdata;
        end else if (prdata !== modulus) begin
          $error("modulus: expected %0d, actual %0d", modulus, prdata);
          mismatches++;
        end
      end
    end
    pending = quot_queue.size();
  end

endmodule

### dv/modular_divide_ext_euclid_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_divide_ext_euclid_top_tb
// Stimulus and verdict for the extended-Euclid modular divider.
// Directed items cover field extremes, divisor zero, divisor at and above the
// modulus, and moduli zero, one, two and all ones. Random items follow over
// several moduli, with bursty input, a stalling output and one long output
// hold-off that backs the block up. Checking is done by the checker module.
// ----------------------------------------------------------------------------
module modular_divide_ext_euclid_top_tb;
  import mdee_pkg::*;

  localparam int STALL_LIMIT  = 40000;
  localparam int HOLD_CYCLES  = 8000;
  localparam int DRAIN_CYCLES = 4000;
  localparam int PHASE_ITEMS  = 90;
  localparam int NUM_PHASES   = 8;

  localparam logic [CFG_ADDR_W-1:0] MODULUS_ADDR = {CFG_IDX_MODULUS, 2'b00};
  localparam logic [DIVIDEND_W-1:0] DIVIDEND_MAX = {DIVIDEND_W{1'b1}};
  localparam logic [DIVISOR_W-1:0]  DIVISOR_MAX  = {DIVISOR_W{1'b1}};

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [95:0]           s_tdata;  // dividend[62:0], divisor[94:63], zero[95]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [QUOT_W-1:0]     m_tdata;  // quotient[31:0]
  logic                  m_tuser;  // no_inverse[0]

  int mismatches;
  int pending;
  int idle_cycles;
  bit hold_armed;
  bit hold_done;

  modular_divide_ext_euclid_top #(.MOD_WIDTH(32)) DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  modular_divide_checker u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .mismatches(mismatches), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int mode;
    int span;
    m_tready  = 1'b0;
    hold_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(20, 300);
        repeat (span) begin
          case (mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 4) == 0);
          endcase
          @(negedge clk);
        end
      end
    end
  end

  task automatic send_item(input logic [DIVIDEND_W-1:0] dividend,
                           input logic [DIVISOR_W-1:0] divisor);
    s_tdata  <= {1'b0, divisor, dividend};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic cfg_access(input logic write, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= MODULUS_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_modulus(input logic [CFG_DATA_W-1:0] value);
    drain_results();
    cfg_access(1'b1, value);
    cfg_access(1'b0, '0);
  endtask

  function automatic logic [DIVIDEND_W-1:0] rand_dividend();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: return DIVIDEND_W'($urandom_range(0, 1000));
      1: return DIVIDEND_MAX - DIVIDEND_W'($urandom_range(0, 1000));
      2: return DIVIDEND_W'($urandom);
      default: return wide[DIVIDEND_W-1:0];
    endcase
  endfunction

  function automatic logic [DIVISOR_W-1:0] rand_divisor(input logic [CFG_DATA_W-1:0] m);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom_range(1, 16);
      2: return m;
      3: return m - 1;
      4: return m + $urandom_range(1, 1000);
      5: return m / $urandom_range(2, 7);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] moduli [NUM_PHASES];
    int left;
    int gap;
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    hold_armed = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_item('0, 1);
    send_item(DIVIDEND_MAX, 1);
    send_item(DIVIDEND_MAX, DIVISOR_MAX);
    send_item(12345, '0);
    send_item(7, MOD_RESET);
    send_item(63'd1000000008, MOD_RESET + 1);
    send_item(1, 2);
    send_item(DIVIDEND_MAX, MOD_RESET - 1);
    set_modulus(1);
    send_item(5, 3);
    send_item(DIVIDEND_MAX, DIVISOR_MAX);
    set_modulus(0);
    send_item(5, 3);
    send_item('0, '0);
    set_modulus(2);
    send_item(1, 1);
    send_item(1, '0);
    send_item(DIVIDEND_MAX, DIVISOR_MAX);
    set_modulus(DIVISOR_MAX);
    send_item(DIVIDEND_MAX, 2);
    send_item(DIVIDEND_MAX, 3);
    send_item(DIVIDEND_MAX, DIVISOR_MAX - 1);
    send_item(DIVIDEND_MAX, 65537);

    moduli = '{32'd4294967291, MOD_RESET, 32'd65537, 32'd998244353, $urandom,
               $urandom_range(2, 300), 32'd1000000, DIVISOR_MAX};
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_modulus(moduli[p]);
      left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (left == 0) begin
          gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
          end
          left = $urandom_range(1, 8);
        end
        send_item(rand_dividend(), rand_divisor(moduli[p]));
        left--;
        if (p == 0 && n == 10) hold_armed = 1'b1;
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### modular_divide_ext_euclid_top.f
hw/rtl/mdee_pkg.sv
hw/rtl/mdee_alu.sv
hw/rtl/mdee_seq.sv
hw/rtl/modular_divide_ext_euclid_top.sv
dv/modular_divide_checker.sv
dv/modular_divide_ext_euclid_top_tb.sv
